>>> hw/rtl/a3m_pkg.sv
// a3m_pkg: shared types and constants for the 3cosmul analogy search block
// used by a3m_mul and analogy_3cosmul_argmax; no dependencies
`timescale 1ns / 1ps

package a3m_pkg;

  // command codes of an input word
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENTRIES = 2'd0,
    CFG_DIMS    = 2'd1,
    CFG_EPSILON = 2'd2
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [10:0] ENTRIES_RESET = 11'd1024;
  localparam logic [9:0]  DIMS_RESET    = 10'd300;
  localparam logic [30:0] EPSILON_RESET = 31'd1073742;

  // one in Q2.30
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_W   = 33;
  localparam int unsigned PROD_W  = 66;
  // score arithmetic widths
  localparam int unsigned COS_W   = 31;
  localparam int unsigned NUM_W   = 61;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned CROSS_W = 93;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_ISSUE,
    ST_DRAIN,
    ST_COS,
    ST_SCORE,
    ST_DONE
  } state_e;

  // steps of the score compare sequence
  typedef enum logic [2:0] {
    SC_NUM,
    SC_LHS_LO,
    SC_LHS_HI,
    SC_RHS_LO,
    SC_RHS_HI,
    SC_CMP
  } score_step_e;

endpackage

>>> hw/rtl/a3m_mul.sv
// a3m_mul: shared signed 33x33 multiplier with registered product
// depends on a3m_pkg for operand and product widths
`timescale 1ns / 1ps

module a3m_mul (
  input  logic                                clk_i,
  input  logic signed [a3m_pkg::MUL_W-1:0]    op_a_i,
  input  logic signed [a3m_pkg::MUL_W-1:0]    op_b_i,
  output logic signed [a3m_pkg::PROD_W-1:0]   prod_o
);

  logic signed [a3m_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a3m_pkg::PROD_W'(op_a_i) * a3m_pkg::PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/a3m_store.sv
// a3m_store: vector element memory, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module a3m_store #(
  parameter int unsigned DEPTH  = 524288,
  parameter int unsigned ADDR_W = 19
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/analogy_3cosmul_argmax.sv
// analogy_3cosmul_argmax: word analogy search with 3cosmul scoring over a vector store
// depends on a3m_pkg, a3m_store and a3m_mul
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_stall_o): a word with cmd_i = write stores one
//   element in the vector store; a word with cmd_i = query names a, b, c
//   and starts a scan; in_stall_o stays high until the result is loaded for output
// - output channel (out_valid_o / out_stall_i): one word per query holding the best
//   entry and a found flag; a stalled result holds and a finished scan waits for it
// - config channel (cfg_valid_i / cfg_ready_o): always ready, write only while idle
// - a query reads four memory words (candidate, a, b, c) per dimension through the
//   single read port and one shared multiplier; entries a, b and c are skipped, not scored
// - the memory read port is the limit: one element per cycle
// - reset clears control state and loads the configuration defaults; the store is
//   undefined until written and gets no clearing pass
module analogy_3cosmul_argmax #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_DIM     = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [9:0]         entry_i,
  input  logic [8:0]         dim_index_i,
  input  logic signed [15:0] element_i,
  input  logic [9:0]         first_word_i,
  input  logic [9:0]         second_word_i,
  input  logic [9:0]         third_word_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         best_entry_o,
  output logic               found_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned EIDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DCNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W = EIDX_W + DIM_W;
  localparam int unsigned DEPTH  = MAX_ENTRIES * (2 ** DIM_W);
  // dot products of up to MAX_DIM terms of magnitude 2^30
  localparam int unsigned ACC_W  = 32 + DIM_W;
  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(a3m_pkg::ONE_Q30);

  // configuration registers
  logic [10:0] entries_q;
  logic [9:0]  dims_q;
  logic [30:0] eps_q;

  // control
  a3m_pkg::state_e      state_q, state_d;
  a3m_pkg::score_step_e step_q;
  logic [CNT_W-1:0]     cand_q, n_q;
  logic [DCNT_W-1:0]    d_q;
  logic [DIM_W-1:0]     k_q;
  logic [1:0]           phase_q;
  logic [9:0]           a_q, b_q, c_q;

  // read and multiply pipeline tags
  logic       rd_v_q, rd_zero_q, mul_v_q;
  logic [1:0] rd_tag_q, mul_tag_q;

  // datapath
  logic signed [15:0]      xi_q;
  logic signed [ACC_W-1:0] acc_q [1:3];
  logic [a3m_pkg::COS_W-1:0]   sa_q, sb_q, sc_q;
  logic [a3m_pkg::NUM_W-1:0]   num_q, best_num_q;
  logic [a3m_pkg::DEN_W-1:0]   den_q, best_den_q;
  logic [a3m_pkg::CROSS_W-1:0] lhs_q, rhs_q;
  logic [CNT_W-1:0]            best_q;
  logic                        found_q;

  // output register
  logic       out_valid_q, out_found_q;
  logic [9:0] out_best_q;

  // decoded control, from the blocks below
  logic                         in_acc, cfg_acc, mem_we, skip, last_issue, drained, beats;
  logic                         out_load, take;
  logic [ADDR_W-1:0]            waddr, raddr;
  logic [EIDX_W-1:0]            entry_sel;
  logic                         word_zero;
  logic signed [a3m_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [a3m_pkg::PROD_W-1:0] prod;
  logic [15:0]                  rdata;
  logic [a3m_pkg::NUM_W-1:0]    take_num;
  logic [a3m_pkg::CROSS_W-1:0]  rhs_full;

  // clamp to [-1, 1] and shift into [0, 1]
  function automatic logic [a3m_pkg::COS_W-1:0] cos_of(input logic signed [ACC_W-1:0] dot);
    logic signed [ACC_W-1:0] clamped;
    logic [ACC_W-1:0]        shifted;
    begin
      clamped = dot;
      if (dot > ACC_ONE) clamped = ACC_ONE;
      else if (dot < -ACC_ONE) clamped = -ACC_ONE;
      shifted = clamped + ACC_ONE;
      cos_of  = shifted[31:1];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= a3m_pkg::ENTRIES_RESET;
      dims_q    <= a3m_pkg::DIMS_RESET;
      eps_q     <= a3m_pkg::EPSILON_RESET;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        a3m_pkg::CFG_ENTRIES: entries_q <= cfg_data_i[10:0];
        a3m_pkg::CFG_DIMS:    dims_q    <= cfg_data_i[9:0];
        a3m_pkg::CFG_EPSILON: eps_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // store and shared multiplier
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != a3m_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign mem_we     = in_acc && (cmd_i == a3m_pkg::CMD_WRITE)
                      && (32'(entry_i) < MAX_ENTRIES) && (32'(dim_index_i) < MAX_DIM);
  assign waddr      = {EIDX_W'(entry_i), DIM_W'(dim_index_i)};

  a3m_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  a3m_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  assign skip = (32'(cand_q) == 32'(a_q)) || (32'(cand_q) == 32'(b_q))
                || (32'(cand_q) == 32'(c_q));
  assign last_issue = (phase_q == 2'd3) && (32'(k_q) == 32'(d_q) - 32'd1);
  assign drained    = ~rd_v_q & ~mul_v_q;
  assign out_load   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      a3m_pkg::ST_IDLE: begin
        if (in_acc && cmd_i == a3m_pkg::CMD_QUERY) state_d = a3m_pkg::ST_NEXT;
      end
      a3m_pkg::ST_NEXT: begin
        if (cand_q == n_q) state_d = a3m_pkg::ST_DONE;
        else if (!skip) state_d = (d_q == '0) ? a3m_pkg::ST_COS : a3m_pkg::ST_ISSUE;
      end
      a3m_pkg::ST_ISSUE: begin
        if (last_issue) state_d = a3m_pkg::ST_DRAIN;
      end
      a3m_pkg::ST_DRAIN: begin
        if (drained) state_d = a3m_pkg::ST_COS;
      end
      a3m_pkg::ST_COS: state_d = a3m_pkg::ST_SCORE;
      a3m_pkg::ST_SCORE: begin
        if ((step_q == a3m_pkg::SC_LHS_LO && !found_q) || step_q == a3m_pkg::SC_CMP) begin
          state_d = a3m_pkg::ST_NEXT;
        end
      end
      a3m_pkg::ST_DONE: begin
        if (out_load) state_d = a3m_pkg::ST_IDLE;
      end
      default: state_d = a3m_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs of the sequencer: read address and multiplier operands
  // ---------------------------------------------------------------------------
  assign rhs_full = rhs_q + a3m_pkg::CROSS_W'({prod[60:0], 32'd0});
  assign beats    = lhs_q > rhs_full;

  always_comb begin
    entry_sel = EIDX_W'(cand_q);
    word_zero = 1'b0;
    case (phase_q)
      2'd1: begin
        entry_sel = EIDX_W'(a_q);
        word_zero = 32'(a_q) >= MAX_ENTRIES;
      end
      2'd2: begin
        entry_sel = EIDX_W'(b_q);
        word_zero = 32'(b_q) >= MAX_ENTRIES;
      end
      2'd3: begin
        entry_sel = EIDX_W'(c_q);
        word_zero = 32'(c_q) >= MAX_ENTRIES;
      end
      default: ;
    endcase
    raddr = {entry_sel, k_q};

    // dot product mode by default: candidate element times query element
    mul_a = a3m_pkg::MUL_W'(xi_q);
    mul_b = rd_zero_q ? '0 : a3m_pkg::MUL_W'($signed(rdata));
    take  = 1'b0;
    take_num = num_q;
    if (state_q == a3m_pkg::ST_SCORE) begin
      case (step_q)
        a3m_pkg::SC_NUM: begin
          mul_a = a3m_pkg::MUL_W'(sb_q);
          mul_b = a3m_pkg::MUL_W'(sc_q);
        end
        a3m_pkg::SC_LHS_LO: begin
          mul_a = a3m_pkg::MUL_W'(prod[31:0]);
          mul_b = a3m_pkg::MUL_W'(best_den_q);
          take  = ~found_q;
          take_num = prod[a3m_pkg::NUM_W-1:0];
        end
        a3m_pkg::SC_LHS_HI: begin
          mul_a = a3m_pkg::MUL_W'(num_q[60:32]);
          mul_b = a3m_pkg::MUL_W'(best_den_q);
        end
        a3m_pkg::SC_RHS_LO: begin
          mul_a = a3m_pkg::MUL_W'(best_num_q[31:0]);
          mul_b = a3m_pkg::MUL_W'(den_q);
        end
        a3m_pkg::SC_RHS_HI: begin
          mul_a = a3m_pkg::MUL_W'(best_num_q[60:32]);
          mul_b = a3m_pkg::MUL_W'(den_q);
        end
        a3m_pkg::SC_CMP: take = beats;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= a3m_pkg::ST_IDLE;
      step_q      <= a3m_pkg::SC_NUM;
      cand_q      <= '0;
      n_q         <= '0;
      d_q         <= '0;
      k_q         <= '0;
      phase_q     <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // read valid is registered from the issue state, multiply valid from read valid of a, b, c words
      rd_v_q  <= (state_q == a3m_pkg::ST_ISSUE);
      mul_v_q <= rd_v_q && (rd_tag_q != 2'd0);

      case (state_q)
        a3m_pkg::ST_IDLE: begin
          if (in_acc && cmd_i == a3m_pkg::CMD_QUERY) begin
            cand_q  <= '0;
            found_q <= 1'b0;
            n_q <= (32'(entries_q) < MAX_ENTRIES) ? CNT_W'(entries_q) : CNT_W'(MAX_ENTRIES);
            d_q <= (32'(dims_q) < MAX_DIM) ? DCNT_W'(dims_q) : DCNT_W'(MAX_DIM);
          end
        end
        a3m_pkg::ST_NEXT: begin
          k_q     <= '0;
          phase_q <= '0;
          step_q  <= a3m_pkg::SC_NUM;
          if (cand_q != n_q && skip) cand_q <= cand_q + 1'b1;
        end
        a3m_pkg::ST_ISSUE: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd3) k_q <= k_q + 1'b1;
        end
        a3m_pkg::ST_SCORE: begin
          case (step_q)
            a3m_pkg::SC_NUM:    step_q <= a3m_pkg::SC_LHS_LO;
            a3m_pkg::SC_LHS_LO: step_q <= a3m_pkg::SC_LHS_HI;
            a3m_pkg::SC_LHS_HI: step_q <= a3m_pkg::SC_RHS_LO;
            a3m_pkg::SC_RHS_LO: step_q <= a3m_pkg::SC_RHS_HI;
            a3m_pkg::SC_RHS_HI: step_q <= a3m_pkg::SC_CMP;
            default:            step_q <= a3m_pkg::SC_NUM;
          endcase
          if (take) found_q <= 1'b1;
          if (state_d == a3m_pkg::ST_NEXT) cand_q <= cand_q + 1'b1;
        end
        default: ;
      endcase

      if (state_q == a3m_pkg::ST_DONE && out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    rd_tag_q  <= phase_q;
    rd_zero_q <= word_zero;
    mul_tag_q <= rd_tag_q;

    if (in_acc && cmd_i == a3m_pkg::CMD_QUERY) begin
      a_q <= first_word_i;
      b_q <= second_word_i;
      c_q <= third_word_i;
    end

    // candidate element is held for the three products that follow it
    if (rd_v_q && rd_tag_q == 2'd0) xi_q <= $signed(rdata);

    if (state_q == a3m_pkg::ST_NEXT) begin
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      acc_q[3] <= '0;
    end else if (mul_v_q) begin
      acc_q[mul_tag_q] <= acc_q[mul_tag_q] + ACC_W'($signed(prod[31:0]));
    end

    // clamp to [-1, 1] and shift into [0, 1]
    if (state_q == a3m_pkg::ST_COS) begin
      sa_q <= cos_of(acc_q[1]);
      sb_q <= cos_of(acc_q[2]);
      sc_q <= cos_of(acc_q[3]);
    end

    if (state_q == a3m_pkg::ST_SCORE) begin
      case (step_q)
        a3m_pkg::SC_NUM:    den_q <= a3m_pkg::DEN_W'(sa_q) + a3m_pkg::DEN_W'(eps_q);
        a3m_pkg::SC_LHS_LO: num_q <= prod[a3m_pkg::NUM_W-1:0];
        a3m_pkg::SC_LHS_HI: lhs_q <= a3m_pkg::CROSS_W'(prod[63:0]);
        a3m_pkg::SC_RHS_LO: lhs_q <= lhs_q + a3m_pkg::CROSS_W'({prod[60:0], 32'd0});
        a3m_pkg::SC_RHS_HI: rhs_q <= a3m_pkg::CROSS_W'(prod[63:0]);
        default: ;
      endcase
      if (take) begin
        best_q     <= cand_q;
        best_num_q <= take_num;
        best_den_q <= den_q;
      end
    end

    if (state_q == a3m_pkg::ST_DONE && out_load) begin
      out_found_q <= found_q;
      out_best_q  <= found_q ? 10'(best_q) : 10'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_entry_o = out_best_q;
  assign found_o      = out_found_q;

`ifndef SYNTHESIS
  // read data only ever follows a read issue
  a_rd_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> $past(state_q) == a3m_pkg::ST_ISSUE)
    else $error("read valid without an issue");

  // a product is accumulated only after a query element read
  a_mul_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_v_q |-> $past(rd_v_q) && $past(rd_tag_q) != 2'd0)
    else $error("product without a query read");

  // the pipeline is empty before the cosines are taken
  a_drained_at_cos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == a3m_pkg::ST_COS |-> !rd_v_q && !mul_v_q)
    else $error("cosines taken with products in flight");

  // the candidate counter never passes the scan count
  a_cand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != a3m_pkg::ST_IDLE |-> cand_q <= n_q)
    else $error("candidate beyond scan count");
`endif

endmodule
